// ===== hdl/triangle_primitive_assembler_assert.svh =====
// Assertion macros used by the triangle primitive assembler checker.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define TPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("triangle primitive assembler: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define TPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("triangle primitive assembler: next-cycle check failed");

`endif

// ===== hdl/tpa_pkg.sv =====
// Shared types and constants of the triangle primitive assembler.
`timescale 1ns / 1ps

package tpa_pkg;

	// Field widths.
	localparam int FIELD_W = 32;
	localparam int INDEX_W = 32;
	localparam int TOPO_W = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	// Only the low INDEX_W bits of an index take part.
	localparam logic [FIELD_W-1:0] INDEX_MASK = FIELD_W'((64'd1 << INDEX_W) - 64'd1);

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TOPOLOGY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b1;

	// Topology codes; the unused code behaves as a list.
	localparam logic [TOPO_W-1:0] TOPO_LIST = 2'd0;
	localparam logic [TOPO_W-1:0] TOPO_STRIP = 2'd1;
	localparam logic [TOPO_W-1:0] TOPO_FAN = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_TRI = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LISTCOUNT = 2'd2;

	// Work handed from the front to the back.
	typedef enum logic [1:0] {
		OP_TRI,        // triangle kept as it is
		OP_TRI_CHECK,  // triangle dropped when two corners repeat
		OP_RANGE,      // index out of range
		OP_COUNT       // list count not a multiple of three
	} op_t;

	typedef struct packed {
		op_t op;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] c;
	} entry_t;

	// Configuration as the front sees it.
	typedef struct packed {
		logic [TOPO_W-1:0] topology;
		logic [FIELD_W-1:0] vertex_count;
	} cfg_t;

endpackage

// ===== hdl/tpa_if.sv =====
// Channel interfaces of the triangle primitive assembler.
`timescale 1ns / 1ps

interface tpa_vertex_if;
	import tpa_pkg::*;

	logic valid;
	logic ready;
	logic [FIELD_W-1:0] vertex_index;
	logic last_in_primitive;

	modport source(output valid, output vertex_index, output last_in_primitive, input ready);
	modport sink(input valid, input vertex_index, input last_in_primitive, output ready);
endinterface

interface tpa_triangle_if;
	import tpa_pkg::*;

	logic valid;
	logic ready;
	logic [FIELD_W-1:0] corner_a;
	logic [FIELD_W-1:0] corner_b;
	logic [FIELD_W-1:0] corner_c;
	logic [STATUS_W-1:0] status;

	modport source(output valid, output corner_a, output corner_b, output corner_c,
		output status, input ready);
	modport sink(input valid, input corner_a, input corner_b, input corner_c,
		input status, output ready);
endinterface

// ===== hdl/tpa_front.sv =====
// Front part: accepts index beats, tracks the topology window and queues work.
`timescale 1ns / 1ps

module tpa_front (
	input  logic clk,
	input  logic arst_n,
	input  tpa_pkg::cfg_t cfg,
	tpa_vertex_if.sink vertex,
	input  logic queue_full,
	output logic push,
	output tpa_pkg::entry_t push_data
);
	import tpa_pkg::*;

	logic [FIELD_W-1:0] fan_center_q, older_q, newer_q;
	logic [1:0] list_phase_q, seen_q;
	logic parity_q, discard_q;

	logic [FIELD_W-1:0] fan_center_d, older_d, newer_d;
	logic [1:0] list_phase_d, seen_d;
	logic parity_d, discard_d;

	logic [FIELD_W-1:0] idx;
	logic accept;
	logic want;
	entry_t work;

	assign vertex.ready = !queue_full;
	assign accept = vertex.valid && vertex.ready;
	assign idx = vertex.vertex_index & INDEX_MASK;

	// Window update and classification of the incoming index.
	always_comb begin
		fan_center_d = fan_center_q;
		older_d = older_q;
		newer_d = newer_q;
		list_phase_d = list_phase_q;
		seen_d = seen_q;
		parity_d = parity_q;
		discard_d = discard_q;
		want = 1'b0;
		work = '{op: OP_RANGE, a: '0, b: '0, c: '0};

		if (discard_q || cfg.vertex_count == '0) begin
			// Rest of the primitive, or every index while the vertex count is zero, is dropped silently.
		end else if (idx >= cfg.vertex_count) begin
			want = 1'b1;
			discard_d = 1'b1;
		end else begin
			case (cfg.topology)
				TOPO_STRIP: begin
					if (seen_q >= 2'd2) begin
						want = 1'b1;
						work.op = OP_TRI_CHECK;
						work.a = parity_q ? newer_q : older_q;
						work.b = parity_q ? older_q : newer_q;
						work.c = idx;
						parity_d = !parity_q;
					end else begin
						seen_d = seen_q + 2'd1;
					end
					older_d = newer_q;
					newer_d = idx;
				end
				TOPO_FAN: begin
					if (seen_q == 2'd0) begin
						fan_center_d = idx;
						seen_d = 2'd1;
					end else if (seen_q == 2'd1) begin
						newer_d = idx;
						seen_d = 2'd2;
					end else begin
						want = 1'b1;
						work.op = OP_TRI_CHECK;
						work.a = fan_center_q;
						work.b = newer_q;
						work.c = idx;
						newer_d = idx;
					end
				end
				default: begin
					if (list_phase_q == 2'd0) begin
						older_d = idx;
						list_phase_d = 2'd1;
					end else if (list_phase_q == 2'd1) begin
						newer_d = idx;
						list_phase_d = 2'd2;
					end else begin
						want = 1'b1;
						work.op = OP_TRI;
						work.a = older_q;
						work.b = newer_q;
						work.c = idx;
						list_phase_d = 2'd0;
					end
					// An incomplete triple at the end of the primitive is an error.
					if (vertex.last_in_primitive && list_phase_d != 2'd0) begin
						want = 1'b1;
						work = '{op: OP_COUNT, a: '0, b: '0, c: '0};
					end
				end
			endcase
		end

		// Every primitive starts from a clean window.
		if (vertex.last_in_primitive) begin
			fan_center_d = '0;
			older_d = '0;
			newer_d = '0;
			list_phase_d = '0;
			seen_d = '0;
			parity_d = 1'b0;
			discard_d = 1'b0;
		end
	end

	assign push = accept && want;
	assign push_data = work;

	// Window and primitive state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_center_q <= '0;
			older_q <= '0;
			newer_q <= '0;
			list_phase_q <= '0;
			seen_q <= '0;
			parity_q <= 1'b0;
			discard_q <= 1'b0;
		end else if (accept) begin
			fan_center_q <= fan_center_d;
			older_q <= older_d;
			newer_q <= newer_d;
			list_phase_q <= list_phase_d;
			seen_q <= seen_d;
			parity_q <= parity_d;
			discard_q <= discard_d;
		end
	end

endmodule

// ===== hdl/tpa_queue.sv =====
// Short first-in first-out queue between the front and the back.
`timescale 1ns / 1ps

module tpa_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tpa_pkg::entry_t push_data,
	input  logic pop,
	output logic full,
	output logic empty,
	output tpa_pkg::entry_t head
);
	import tpa_pkg::*;

	entry_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/tpa_back.sv =====
// Back part: drops repeated-corner triangles and holds the result beat.
`timescale 1ns / 1ps

module tpa_back (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  tpa_pkg::entry_t head,
	output logic pop,
	tpa_triangle_if.source triangle
);
	import tpa_pkg::*;

	logic valid_q;
	logic [FIELD_W-1:0] a_q, b_q, c_q;
	logic [STATUS_W-1:0] status_q;
	logic distinct;
	logic keep;

	// Take work whenever the output register is free or being emptied.
	assign pop = !empty && (!valid_q || triangle.ready);

	assign distinct = (head.a != head.b) && (head.b != head.c) && (head.a != head.c);
	assign keep = (head.op != OP_TRI_CHECK) || distinct;

	// Output handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= keep;
		end else if (triangle.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload; error beats carry zero corners.
	always_ff @(posedge clk) begin
		if (pop) begin
			case (head.op)
				OP_TRI, OP_TRI_CHECK: begin
					a_q <= head.a;
					b_q <= head.b;
					c_q <= head.c;
					status_q <= ST_TRI;
				end
				OP_RANGE: begin
					a_q <= '0;
					b_q <= '0;
					c_q <= '0;
					status_q <= ST_RANGE;
				end
				default: begin
					a_q <= '0;
					b_q <= '0;
					c_q <= '0;
					status_q <= ST_LISTCOUNT;
				end
			endcase
		end
	end

	assign triangle.valid = valid_q;
	assign triangle.corner_a = a_q;
	assign triangle.corner_b = b_q;
	assign triangle.corner_c = c_q;
	assign triangle.status = status_q;

endmodule

// ===== hdl/triangle_primitive_assembler.sv =====
// A result beat passes through the queue and then the output register before it is offered.
// Throughput: one index beat per cycle; the two-entry queue and the output register hold
// three pending results, so a long output stall fills them and then holds the input off.
// Reset (arst_n low, asynchronous): topology list, vertex count zero, window cleared,
// queue and output empty.
`timescale 1ns / 1ps

module triangle_primitive_assembler (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [tpa_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tpa_pkg::FIELD_W-1:0] wr_data,
	tpa_vertex_if.sink vertex,
	tpa_triangle_if.source triangle
);
	import tpa_pkg::*;

	logic [TOPO_W-1:0] topology_q;
	logic [FIELD_W-1:0] vertex_count_q;
	cfg_t cfg;

	logic push, pop, full, empty;
	entry_t push_data, head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topology_q <= TOPO_LIST;
			vertex_count_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TOPOLOGY: topology_q <= wr_data[TOPO_W-1:0];
				REG_VERTEX_COUNT: vertex_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = '{topology: topology_q, vertex_count: vertex_count_q};

	tpa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.vertex(vertex),
		.queue_full(full),
		.push(push),
		.push_data(push_data)
	);

	tpa_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.full(full),
		.empty(empty),
		.head(head)
	);

	tpa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.triangle(triangle)
	);

endmodule

// ===== hdl/tpa_checker.sv =====
// Port-level checks of the triangle primitive assembler, bound to the top level.
`timescale 1ns / 1ps
`include "triangle_primitive_assembler_assert.svh"

module tpa_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [tpa_pkg::FIELD_W-1:0] corner_a,
	input logic [tpa_pkg::FIELD_W-1:0] corner_b,
	input logic [tpa_pkg::FIELD_W-1:0] corner_c,
	input logic [tpa_pkg::STATUS_W-1:0] status
);
	import tpa_pkg::*;

	logic held_beat;
	logic err_beat;
	logic zero_corners;
	logic known_status;
	logic [3*FIELD_W+STATUS_W-1:0] payload;

	assign held_beat = out_valid && !out_ready;
	assign err_beat = out_valid && (status != ST_TRI);
	assign zero_corners = (corner_a == '0) && (corner_b == '0) && (corner_c == '0);
	assign known_status = status inside {ST_TRI, ST_RANGE, ST_LISTCOUNT};
	assign payload = {corner_a, corner_b, corner_c, status};

	// A held result beat stays offered until it is taken.
	`TPA_ASSERT_NEXT(a_hold_result, clk, arst_n, held_beat, out_valid)

	// A held result beat keeps its payload.
	`TPA_ASSERT_NEXT(a_hold_payload, clk, arst_n, held_beat, $stable(payload))

	// Error beats carry zero corners.
	`TPA_ASSERT_SAME(a_error_zero, clk, arst_n, err_beat, zero_corners)

	// Only the three defined status codes appear.
	`TPA_ASSERT_SAME(a_status_code, clk, arst_n, out_valid, known_status)

endmodule

bind triangle_primitive_assembler tpa_checker u_tpa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(triangle.valid),
	.out_ready(triangle.ready),
	.corner_a(triangle.corner_a),
	.corner_b(triangle.corner_b),
	.corner_c(triangle.corner_c),
	.status(triangle.status)
);
